>>> rtl/core/bwd_pkg.sv
// ----------------------------------------------------------------------------
// bwd_pkg
// Shared types, register codes and defaults for the boundary wire detector.
// ----------------------------------------------------------------------------
package bwd_pkg;

  localparam int unsigned SampleW      = 12;
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned ThrW         = 12;
  localparam int unsigned DebW         = 8;
  localparam int unsigned GapW         = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [ThrW-1:0] ThrDefault   = ThrW'(1200);
  localparam logic [DebW-1:0] LimitDefault = DebW'(20);
  localparam logic [DebW-1:0] DecayDefault = DebW'(3);
  localparam logic [GapW-1:0] RearmDefault = GapW'(5000 / 50);
  localparam logic [GapW-1:0] LossDefault  = GapW'(50000 / 50);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIFF_THRESHOLD = 3'd0,
    REG_DEBOUNCE_LIMIT = 3'd1,
    REG_DEBOUNCE_DECAY = 3'd2,
    REG_REARM_SAMPLES  = 3'd3,
    REG_LOSS_SAMPLES   = 3'd4,
    REG_MOUNT_DOWN     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_IN   = 2'd1,
    ST_OUT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    POS_BOTH_IN  = 3'd0,
    POS_L_IN_R_OUT = 3'd1,
    POS_L_OUT_R_IN = 3'd2,
    POS_BOTH_OUT = 3'd3,
    POS_FAULT    = 3'd4
  } position_e;

  typedef struct packed {
    logic [SampleW-1:0] left_positive;
    logic [SampleW-1:0] left_negative;
    logic [SampleW-1:0] right_positive;
    logic [SampleW-1:0] right_negative;
  } bwd_in_t;

  typedef struct packed {
    status_e   left_status;
    status_e   right_status;
    position_e position;
  } bwd_out_t;

  typedef struct packed {
    logic [ThrW-1:0] diff_threshold;
    logic [DebW-1:0] debounce_limit;
    logic [DebW-1:0] debounce_decay;
    logic [GapW-1:0] rearm_samples;
    logic [GapW-1:0] loss_samples;
    logic            mount_down;
  } bwd_cfg_t;

  function automatic position_e bwd_map(status_e l, status_e r, logic mount_down);
    position_e p;
    p = POS_FAULT;
    if (l == ST_IN && r == ST_IN) begin
      p = mount_down ? POS_BOTH_IN : POS_BOTH_OUT;
    end else if (l == ST_IN && r == ST_OUT) begin
      p = mount_down ? POS_L_IN_R_OUT : POS_L_OUT_R_IN;
    end else if (l == ST_OUT && r == ST_IN) begin
      p = mount_down ? POS_L_OUT_R_IN : POS_L_IN_R_OUT;
    end else if (l == ST_OUT && r == ST_OUT) begin
      p = mount_down ? POS_BOTH_OUT : POS_BOTH_IN;
    end
    return p;
  endfunction

endpackage

>>> rtl/core/boundary_wire_detector.sv
// ----------------------------------------------------------------------------
// boundary_wire_detector
// Boundary wire position detector for a left and a right coil sensor pair.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one ADC sample set per
// beat, positive and negative coil readings for both sensors.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// input beat, with the debounced left and right status and the position code.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// register writes, taken in any cycle; write only while the block is empty.
// Path: a taken sample set waits in the input register and moves into the
// result register when the result register is empty or its result is taken.
// Throughput: one sample set per cycle while the receiver does not stall, set
// by the single pass from the input register through the channel logic into the result register.
// When the receiver stalls, the result holds; the input register takes one
// more beat, then in_stall_o rises until the result is taken.
// Reset clears both channels to status none with all counters at zero and
// loads the register defaults.
// ----------------------------------------------------------------------------
module boundary_wire_detector #(
  parameter int unsigned SAMPLE_BITS = bwd_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bwd_pkg::bwd_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bwd_pkg::bwd_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bwd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bwd_pkg::CfgDataW-1:0] cfg_data_i
);
  import bwd_pkg::*;

  bwd_cfg_t cfg;
  logic     in_valid_q, in_valid_d;
  bwd_in_t  in_data_q;
  logic     out_valid_q, out_valid_d;
  bwd_out_t out_data_q, out_data_d;
  logic     advance, in_take;
  status_e  left_d, right_d;

  bwd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  bwd_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .pos_i     (in_data_q.left_positive),
    .neg_i     (in_data_q.left_negative),
    .cfg_i     (cfg),
    .status_d_o(left_d)
  );

  bwd_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .pos_i     (in_data_q.right_positive),
    .neg_i     (in_data_q.right_negative),
    .cfg_i     (cfg),
    .status_d_o(right_d)
  );

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_comb begin
    out_data_d.left_status  = left_d;
    out_data_d.right_status = right_d;
    out_data_d.position     = bwd_map(left_d, right_d, cfg.mount_down);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, loaded on their beat only
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled with room downstream");

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.position == POS_FAULT) ==
                     (out_data_o.left_status == ST_NONE ||
                      out_data_o.right_status == ST_NONE)))
    else $error("position fault code disagrees with statuses");

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a sample set");
`endif

endmodule

>>> rtl/core/bwd_cfg.sv
// ----------------------------------------------------------------------------
// bwd_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module bwd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bwd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bwd_pkg::CfgDataW-1:0]  cfg_data_i,
  output bwd_pkg::bwd_cfg_t             cfg_o
);
  import bwd_pkg::*;

  bwd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DIFF_THRESHOLD: cfg_d.diff_threshold = cfg_data_i[ThrW-1:0];
        REG_DEBOUNCE_LIMIT: cfg_d.debounce_limit = cfg_data_i[DebW-1:0];
        REG_DEBOUNCE_DECAY: cfg_d.debounce_decay = cfg_data_i[DebW-1:0];
        REG_REARM_SAMPLES:  cfg_d.rearm_samples  = cfg_data_i[GapW-1:0];
        REG_LOSS_SAMPLES:   cfg_d.loss_samples   = cfg_data_i[GapW-1:0];
        REG_MOUNT_DOWN:     cfg_d.mount_down     = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_threshold <= ThrDefault;
      cfg_q.debounce_limit <= LimitDefault;
      cfg_q.debounce_decay <= DecayDefault;
      cfg_q.rearm_samples  <= RearmDefault;
      cfg_q.loss_samples   <= LossDefault;
      cfg_q.mount_down     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/bwd_channel.sv
// ----------------------------------------------------------------------------
// bwd_channel
// One sensor channel: pulse detect, polarity latch, debounce and gap timers.
// ----------------------------------------------------------------------------
module bwd_channel #(
  parameter int unsigned SAMPLE_BITS = bwd_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [bwd_pkg::SampleW-1:0]  pos_i,
  input  logic [bwd_pkg::SampleW-1:0]  neg_i,
  input  bwd_pkg::bwd_cfg_t            cfg_i,
  output bwd_pkg::status_e             status_d_o
);
  import bwd_pkg::*;

  localparam logic [SampleW-1:0] SMask =
    (SAMPLE_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);

  logic            latch_q, latch_d;
  status_e         pol_q, pol_d;
  status_e         acc_q, acc_d;
  logic [DebW-1:0] deb_q, deb_d;
  logic [GapW-1:0] rearm_q, rearm_d;
  logic [GapW-1:0] loss_q, loss_d;

  logic [SampleW-1:0] p, n, diff;
  logic               pulse;
  status_e            pol_eff;
  logic [DebW-1:0]    deb_inc;
  logic [GapW-1:0]    rearm_inc, loss_inc;

  assign p        = pos_i & SMask;
  assign n        = neg_i & SMask;
  assign diff     = (p > n) ? (p - n) : (n - p);
  assign pulse    = diff > cfg_i.diff_threshold;
  // first pulse of a burst takes the fresh polarity
  assign pol_eff  = latch_q ? pol_q : ((p > n) ? ST_IN : ST_OUT);
  assign deb_inc  = (deb_q == {DebW{1'b1}}) ? deb_q : deb_q + DebW'(1);
  assign rearm_inc = rearm_q + GapW'(1);
  assign loss_inc  = loss_q + GapW'(1);

  always_comb begin
    latch_d = latch_q;
    pol_d   = pol_q;
    acc_d   = acc_q;
    deb_d   = deb_q;
    rearm_d = rearm_q;
    loss_d  = loss_q;
    if (pulse) begin
      latch_d = 1'b1;
      pol_d   = pol_eff;
      if (!latch_q) begin
        rearm_d = '0;
        loss_d  = '0;
      end
      if (acc_q != pol_eff) begin
        if (deb_inc > cfg_i.debounce_limit) begin
          deb_d = '0;
          acc_d = pol_eff;
        end else begin
          deb_d = deb_inc;
        end
      end else begin
        deb_d = (deb_q > cfg_i.debounce_decay) ? deb_q - cfg_i.debounce_decay : '0;
      end
    end else begin
      // a wrapped count fires as well, so a zero limit behaves as one
      if (rearm_inc >= cfg_i.rearm_samples || rearm_inc == '0) begin
        rearm_d = '0;
        latch_d = 1'b0;
      end else begin
        rearm_d = rearm_inc;
      end
      if (loss_inc >= cfg_i.loss_samples || loss_inc == '0) begin
        loss_d = '0;
        acc_d  = ST_NONE;
      end else begin
        loss_d = loss_inc;
      end
    end
  end

  assign status_d_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
      pol_q   <= ST_NONE;
      acc_q   <= ST_NONE;
      deb_q   <= '0;
      rearm_q <= '0;
      loss_q  <= '0;
    end else if (en_i) begin
      latch_q <= latch_d;
      pol_q   <= pol_d;
      acc_q   <= acc_d;
      deb_q   <= deb_d;
      rearm_q <= rearm_d;
      loss_q  <= loss_d;
    end
  end

`ifndef SYNTHESIS
  a_latch_has_pol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (pol_q != ST_NONE))
    else $error("latched burst without polarity");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(acc_q) && $stable(deb_q) && $stable(latch_q)))
    else $error("channel state moved without a beat");

  a_accept_clears_deb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && pulse && acc_d != acc_q) |=> (deb_q == '0))
    else $error("debounce count not cleared on new status");
`endif

endmodule
